### rtl/core/mstb_pkg.sv
// ----------------------------------------------------------------------------
// mstb_pkg
// Shared types and constants for the soft timer bank.
// ----------------------------------------------------------------------------
package mstb_pkg;

  localparam int NUM_TIMERS_DEF  = 8;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int MAX_RESULTS     = 8;

  localparam int CMD_W   = 3;
  localparam int INDEX_W = 3;
  localparam int TICKS_W = 32;
  localparam int RES_W   = $clog2(MAX_RESULTS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER   = 3'd0,
    CMD_UNREGISTER = 3'd1,
    CMD_START      = 3'd2,
    CMD_STOP       = 3'd3,
    CMD_RELOAD     = 3'd4,
    CMD_STATUS     = 3'd5,
    CMD_TICK       = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_UNUSED    = 2'd0,
    ST_RUNNING   = 2'd1,
    ST_STOPPED   = 2'd2,
    ST_COMPLETED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD_RD,
    S_CMD_EX,
    S_TICK_RD,
    S_TICK_EX,
    S_TICK_END
  } state_t;

  typedef struct packed {
    logic count_we;
    logic reload_we;
  } store_wr_t;

endpackage

### rtl/core/mstb_req_if.sv
// ----------------------------------------------------------------------------
// mstb_req_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface mstb_req_if;
  logic                            valid;
  logic                            ready;
  logic [mstb_pkg::CMD_W-1:0]      command;
  logic [mstb_pkg::INDEX_W-1:0]    timer_index;
  logic                            timer_mode;
  logic [mstb_pkg::TICKS_W-1:0]    ticks;

  modport source (output valid, command, timer_index, timer_mode, ticks, input ready);
  modport sink (input valid, command, timer_index, timer_mode, ticks, output ready);
endinterface

### rtl/core/mstb_rsp_if.sv
// ----------------------------------------------------------------------------
// mstb_rsp_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface mstb_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic [1:0]                      timer_status;
  logic                            expired;
  logic [mstb_pkg::INDEX_W-1:0]    expired_index;
  logic                            last;

  modport source (output valid, ok, timer_status, expired, expired_index, last, input ready);
  modport sink (input valid, ok, timer_status, expired, expired_index, last, output ready);
endinterface

### rtl/core/multi_channel_soft_timer_bank_top.sv
// ----------------------------------------------------------------------------
// multi_channel_soft_timer_bank_top
// Bank of one-shot / periodic down-count timers driven by commands and ticks.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | command, timer_index, timer_mode, ticks
//  rsp     | out | ok, timer_status, expired, expired_index, last
//
// A command passes through accept, store read and execute into the result register.
// A tick reads each timer in turn from the single-port counter store and passes it
// through the one decrementer, then issues the final result.
// Synchronous rst clears flags, status, store valid bits and the sequencer at once.
// A full result register holds the sequencer until the transaction is taken.
module multi_channel_soft_timer_bank_top #(
  parameter int  NUM_TIMERS  = mstb_pkg::NUM_TIMERS_DEF,
  parameter int  COUNT_WIDTH = mstb_pkg::COUNT_WIDTH_DEF,
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic        clk,
  input  logic        rst,
  mstb_req_if.sink    req,
  mstb_rsp_if.source  rsp
);

  mstb_pkg::store_wr_t     wr;
  logic                    rd_en;
  logic [IDX_W-1:0]        addr;
  logic [COUNT_WIDTH-1:0]  count_wdata;
  logic [COUNT_WIDTH-1:0]  reload_wdata;
  logic [COUNT_WIDTH-1:0]  count_q;
  logic [COUNT_WIDTH-1:0]  reload_q;

  mstb_ctrl #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .rsp          (rsp),
    .rd_en        (rd_en),
    .wr           (wr),
    .addr         (addr),
    .count_wdata  (count_wdata),
    .reload_wdata (reload_wdata),
    .count_q      (count_q),
    .reload_q     (reload_q)
  );

  mstb_store #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .rd_en        (rd_en),
    .wr           (wr),
    .addr         (addr),
    .count_wdata  (count_wdata),
    .reload_wdata (reload_wdata),
    .count_q      (count_q),
    .reload_q     (reload_q)
  );

endmodule

### rtl/core/mstb_store.sv
// ----------------------------------------------------------------------------
// mstb_store
// Counter and reload memories, one port, registered read. Entries not yet
// started read as zero.
// ----------------------------------------------------------------------------
module mstb_store #(
  parameter int  NUM_TIMERS  = mstb_pkg::NUM_TIMERS_DEF,
  parameter int  COUNT_WIDTH = mstb_pkg::COUNT_WIDTH_DEF,
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  mstb_pkg::store_wr_t     wr,
  input  logic [IDX_W-1:0]        addr,
  input  logic [COUNT_WIDTH-1:0]  count_wdata,
  input  logic [COUNT_WIDTH-1:0]  reload_wdata,
  output logic [COUNT_WIDTH-1:0]  count_q,
  output logic [COUNT_WIDTH-1:0]  reload_q
);

  logic [COUNT_WIDTH-1:0] count_mem  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] reload_mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  valid;
  logic [COUNT_WIDTH-1:0] count_rd;
  logic [COUNT_WIDTH-1:0] reload_rd;
  logic                   valid_rd;

  always_ff @(posedge clk) begin
    if (wr.count_we) begin
      count_mem[addr] <= count_wdata;
    end
    if (wr.reload_we) begin
      reload_mem[addr] <= reload_wdata;
    end
    if (rd_en) begin
      count_rd  <= count_mem[addr];
      reload_rd <= reload_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      valid_rd <= 1'b0;
    end else begin
      if (wr.reload_we) begin
        valid[addr] <= 1'b1;
      end
      if (rd_en) begin
        valid_rd <= valid[addr];
      end
    end
  end

  assign count_q  = valid_rd ? count_rd  : '0;
  assign reload_q = valid_rd ? reload_rd : '0;

endmodule

### rtl/core/mstb_ctrl.sv
// ----------------------------------------------------------------------------
// mstb_ctrl
// Sequencer, timer flags, shared decrementer and zero detect, result register.
// ----------------------------------------------------------------------------
module mstb_ctrl #(
  parameter int  NUM_TIMERS  = mstb_pkg::NUM_TIMERS_DEF,
  parameter int  COUNT_WIDTH = mstb_pkg::COUNT_WIDTH_DEF,
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  mstb_req_if.sink                req,
  mstb_rsp_if.source              rsp,
  output logic                    rd_en,
  output mstb_pkg::store_wr_t     wr,
  output logic [IDX_W-1:0]        addr,
  output logic [COUNT_WIDTH-1:0]  count_wdata,
  output logic [COUNT_WIDTH-1:0]  reload_wdata,
  input  logic [COUNT_WIDTH-1:0]  count_q,
  input  logic [COUNT_WIDTH-1:0]  reload_q
);

  localparam int WIDE_W = mstb_pkg::TICKS_W + COUNT_WIDTH;
  localparam int IXW_W  = IDX_W + mstb_pkg::INDEX_W;

  mstb_pkg::state_t state, state_next;

  logic [mstb_pkg::CMD_W-1:0]     cmd_q;
  logic [IDX_W-1:0]               idx_q;
  logic                           in_range_q;
  logic                           mode_q;
  logic [COUNT_WIDTH-1:0]         ticks_q;

  logic [IDX_W-1:0]               walk;
  logic [mstb_pkg::RES_W-1:0]     rep_cnt;
  logic                           pend_valid;
  mstb_pkg::status_t              pend_status;
  logic [mstb_pkg::INDEX_W-1:0]   pend_idx;

  logic [NUM_TIMERS-1:0]          registered;
  logic [NUM_TIMERS-1:0]          periodic;
  mstb_pkg::status_t              status [NUM_TIMERS];

  logic                           out_valid;
  logic                           out_ok;
  mstb_pkg::status_t              out_status;
  logic                           out_expired;
  logic [mstb_pkg::INDEX_W-1:0]   out_idx;
  logic                           out_last;

  logic                           accept;
  logic                           out_free;
  logic [WIDE_W-1:0]              ticks_wide;
  logic [IXW_W-1:0]               req_idx_wide;
  logic [IXW_W-1:0]               walk_wide;
  logic                           walk_last;
  logic                           cur_reg;
  logic                           cur_periodic;
  mstb_pkg::status_t              cur_status;
  logic [COUNT_WIDTH-1:0]         dec;
  logic [COUNT_WIDTH-1:0]         zero_opnd;
  logic                           is_zero;
  logic                           active;
  logic                           hit;
  logic                           room;
  logic                           emit_now;
  logic                           go;

  logic                           load;
  logic                           res_ok;
  mstb_pkg::status_t              res_status;
  logic                           res_expired;
  logic [mstb_pkg::INDEX_W-1:0]   res_idx;
  logic                           res_last;
  logic                           reg_set;
  logic                           reg_clr;
  logic                           mode_we;
  logic                           status_we;
  mstb_pkg::status_t              status_wdata;
  logic                           pend_load;
  logic                           pend_clear;
  logic                           step;

  assign accept       = (state == mstb_pkg::S_IDLE) && req.valid;
  assign req.ready    = (state == mstb_pkg::S_IDLE);
  assign out_free     = !out_valid || rsp.ready;
  assign ticks_wide   = WIDE_W'(req.ticks);
  assign req_idx_wide = IXW_W'(req.timer_index);
  assign walk_wide    = IXW_W'(walk);
  assign walk_last    = (walk == IDX_W'(NUM_TIMERS - 1));

  assign addr         = ((state == mstb_pkg::S_TICK_RD) || (state == mstb_pkg::S_TICK_EX) ||
                         (state == mstb_pkg::S_TICK_END)) ? walk : idx_q;
  assign rd_en        = (state == mstb_pkg::S_CMD_RD) || (state == mstb_pkg::S_TICK_RD);
  assign cur_reg      = registered[addr];
  assign cur_periodic = periodic[addr];
  assign cur_status   = status[addr];

  // shared decrementer and zero detect
  assign dec       = count_q - COUNT_WIDTH'(1);
  assign zero_opnd = (state == mstb_pkg::S_TICK_EX) ? dec :
                     (cmd_q == mstb_pkg::CMD_START) ? ticks_q : reload_q;
  assign is_zero   = (zero_opnd == '0);

  assign active   = cur_reg && (cur_status == mstb_pkg::ST_RUNNING);
  assign hit      = active && is_zero;
  assign room     = (rep_cnt < mstb_pkg::RES_W'(mstb_pkg::MAX_RESULTS));
  assign emit_now = hit && room && pend_valid;
  assign go       = !emit_now || out_free;

  always_comb begin
    load         = 1'b0;
    res_ok       = 1'b1;
    res_status   = cur_status;
    res_expired  = 1'b0;
    res_idx      = '0;
    res_last     = 1'b1;
    wr           = '0;
    count_wdata  = dec;
    reload_wdata = ticks_q;
    reg_set      = 1'b0;
    reg_clr      = 1'b0;
    mode_we      = 1'b0;
    status_we    = 1'b0;
    status_wdata = cur_status;
    pend_load    = 1'b0;
    pend_clear   = 1'b0;
    step         = 1'b0;
    case (state)
      mstb_pkg::S_CMD_EX: begin
        if (out_free) begin
          load = 1'b1;
          if (!in_range_q) begin
            res_ok     = 1'b0;
            res_status = mstb_pkg::ST_UNUSED;
          end else begin
            case (cmd_q)
              mstb_pkg::CMD_REGISTER: begin
                mode_we      = 1'b1;
                reg_set      = 1'b1;
                status_we    = 1'b1;
                status_wdata = mstb_pkg::ST_UNUSED;
                res_status   = mstb_pkg::ST_UNUSED;
              end
              mstb_pkg::CMD_UNREGISTER: begin
                if (cur_reg) begin
                  reg_clr = 1'b1;
                end else begin
                  res_ok = 1'b0;
                end
              end
              mstb_pkg::CMD_START: begin
                if (is_zero) begin
                  res_ok = 1'b0;
                end else begin
                  wr.count_we  = 1'b1;
                  wr.reload_we = 1'b1;
                  count_wdata  = ticks_q;
                  status_we    = 1'b1;
                  status_wdata = mstb_pkg::ST_RUNNING;
                  res_status   = mstb_pkg::ST_RUNNING;
                end
              end
              mstb_pkg::CMD_STOP: begin
                status_we    = 1'b1;
                status_wdata = mstb_pkg::ST_STOPPED;
                res_status   = mstb_pkg::ST_STOPPED;
              end
              mstb_pkg::CMD_RELOAD: begin
                if (!is_zero) begin
                  wr.count_we  = 1'b1;
                  count_wdata  = reload_q;
                  status_we    = 1'b1;
                  status_wdata = mstb_pkg::ST_RUNNING;
                  res_status   = mstb_pkg::ST_RUNNING;
                end
              end
              mstb_pkg::CMD_STATUS: begin
                res_ok = 1'b1;
              end
              default: begin
                res_ok = 1'b0;
              end
            endcase
          end
        end
      end
      mstb_pkg::S_TICK_EX: begin
        if (go) begin
          step = 1'b1;
          if (active) begin
            wr.count_we = 1'b1;
            count_wdata = (hit && cur_periodic) ? reload_q : dec;
          end
          if (hit && !cur_periodic) begin
            status_we    = 1'b1;
            status_wdata = mstb_pkg::ST_COMPLETED;
          end
          if (hit && room) begin
            pend_load = 1'b1;
          end
          if (emit_now) begin
            load        = 1'b1;
            res_status  = pend_status;
            res_expired = 1'b1;
            res_idx     = pend_idx;
            res_last    = 1'b0;
          end
        end
      end
      mstb_pkg::S_TICK_END: begin
        if (out_free) begin
          load       = 1'b1;
          pend_clear = 1'b1;
          if (pend_valid) begin
            res_status  = pend_status;
            res_expired = 1'b1;
            res_idx     = pend_idx;
          end else begin
            res_status = mstb_pkg::ST_UNUSED;
          end
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      mstb_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = (req.command == mstb_pkg::CMD_TICK) ? mstb_pkg::S_TICK_RD :
                                                              mstb_pkg::S_CMD_RD;
        end
      end
      mstb_pkg::S_CMD_RD:  state_next = mstb_pkg::S_CMD_EX;
      mstb_pkg::S_CMD_EX: begin
        if (out_free) begin
          state_next = mstb_pkg::S_IDLE;
        end
      end
      mstb_pkg::S_TICK_RD: state_next = mstb_pkg::S_TICK_EX;
      mstb_pkg::S_TICK_EX: begin
        if (go) begin
          state_next = walk_last ? mstb_pkg::S_TICK_END : mstb_pkg::S_TICK_RD;
        end
      end
      mstb_pkg::S_TICK_END: begin
        if (out_free) begin
          state_next = mstb_pkg::S_IDLE;
        end
      end
      default: state_next = mstb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mstb_pkg::S_IDLE;
      registered <= '0;
      periodic   <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        status[i] <= mstb_pkg::ST_UNUSED;
      end
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      rep_cnt    <= '0;
      walk       <= '0;
    end else begin
      state <= state_next;
      if (reg_set) begin
        registered[addr] <= 1'b1;
      end
      if (reg_clr) begin
        registered[addr] <= 1'b0;
      end
      if (mode_we) begin
        periodic[addr] <= mode_q;
      end
      if (status_we) begin
        status[addr] <= status_wdata;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        walk       <= '0;
        rep_cnt    <= '0;
        pend_valid <= 1'b0;
      end else begin
        if (step && !walk_last) begin
          walk <= walk + IDX_W'(1);
        end
        if (pend_load) begin
          pend_valid <= 1'b1;
          rep_cnt    <= rep_cnt + mstb_pkg::RES_W'(1);
        end
        if (pend_clear) begin
          pend_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= req.command;
      idx_q      <= req_idx_wide[IDX_W-1:0];
      in_range_q <= (32'(req.timer_index) < 32'(NUM_TIMERS));
      mode_q     <= req.timer_mode;
      ticks_q    <= ticks_wide[COUNT_WIDTH-1:0];
    end
    if (pend_load) begin
      pend_status <= status_we ? status_wdata : cur_status;
      pend_idx    <= walk_wide[mstb_pkg::INDEX_W-1:0];
    end
    if (load) begin
      out_ok      <= res_ok;
      out_status  <= res_status;
      out_expired <= res_expired;
      out_idx     <= res_idx;
      out_last    <= res_last;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.ok            = out_ok;
  assign rsp.timer_status  = out_status;
  assign rsp.expired       = out_expired;
  assign rsp.expired_index = out_idx;
  assign rsp.last          = out_last;

endmodule

### tb/multi_channel_soft_timer_bank_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_soft_timer_bank_top_tb
// Self-checking bench for the soft timer bank. A directed table covers the
// corner cases, then random command streams with short periods drive expiries.
// A local model of the bank predicts every result transaction, except where a
// directed row gives its own. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer_bank_top_tb;
  import mstb_pkg::*;

  localparam int NTIM = 8;
  localparam int RANDOM_ITEMS = 440;

  typedef struct packed {
    logic       ok;
    status_t    st;
    logic       expired;
    logic [2:0] index;
    logic       last;
  } timer_result_t;

  typedef struct packed {
    cmd_t          cmd;
    logic [2:0]    index;
    logic          mode;
    logic [31:0]   ticks;
    logic          typed;
    timer_result_t want;
  } stim_row_t;

  localparam timer_result_t R_ZERO_OK  = '{1'b1, ST_UNUSED, 1'b0, 3'd0, 1'b1};
  localparam timer_result_t R_ZERO_ERR = '{1'b0, ST_UNUSED, 1'b0, 3'd0, 1'b1};
  localparam timer_result_t R_RUNNING  = '{1'b1, ST_RUNNING, 1'b0, 3'd0, 1'b1};
  localparam timer_result_t R_STOPPED  = '{1'b1, ST_STOPPED, 1'b0, 3'd0, 1'b1};

  localparam int DIR_ROWS = 22;
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{CMD_STATUS,     3'd0, 1'b0, 32'd0,          1'b1, R_ZERO_OK},
    '{CMD_UNREGISTER, 3'd3, 1'b0, 32'd0,          1'b1, R_ZERO_ERR},
    '{CMD_START,      3'd1, 1'b0, 32'd0,          1'b1, R_ZERO_ERR},
    '{CMD_TICK,       3'd5, 1'b1, 32'hFFFF_FFFF,  1'b1, R_ZERO_OK},
    '{CMD_REGISTER,   3'd0, 1'b0, 32'd0,          1'b1, R_ZERO_OK},
    '{CMD_REGISTER,   3'd1, 1'b1, 32'd0,          1'b1, R_ZERO_OK},
    '{CMD_REGISTER,   3'd7, 1'b1, 32'd0,          1'b1, R_ZERO_OK},
    '{CMD_START,      3'd0, 1'b0, 32'd1,          1'b1, R_RUNNING},
    '{CMD_START,      3'd1, 1'b0, 32'd2,          1'b1, R_RUNNING},
    '{CMD_START,      3'd7, 1'b0, 32'hFFFF_FFFF,  1'b1, R_RUNNING},
    '{CMD_TICK,       3'd0, 1'b0, 32'd0,          1'b0, R_ZERO_OK},
    '{CMD_TICK,       3'd0, 1'b0, 32'd0,          1'b0, R_ZERO_OK},
    '{CMD_RELOAD,     3'd0, 1'b0, 32'd0,          1'b0, R_ZERO_OK},
    '{CMD_STOP,       3'd7, 1'b0, 32'd0,          1'b1, R_STOPPED},
    '{CMD_TICK,       3'd0, 1'b0, 32'd0,          1'b0, R_ZERO_OK},
    '{CMD_RELOAD,     3'd2, 1'b0, 32'd0,          1'b0, R_ZERO_OK},
    '{CMD_REGISTER,   3'd1, 1'b0, 32'd0,          1'b1, R_ZERO_OK},
    '{CMD_START,      3'd2, 1'b0, 32'd5,          1'b0, R_ZERO_OK},
    '{CMD_UNREGISTER, 3'd0, 1'b0, 32'd0,          1'b0, R_ZERO_OK},
    '{CMD_RELOAD,     3'd1, 1'b0, 32'd0,          1'b0, R_ZERO_OK},
    '{CMD_START,      3'd6, 1'b0, 32'h8000_0000,  1'b0, R_ZERO_OK},
    '{CMD_TICK,       3'd0, 1'b0, 32'd0,          1'b0, R_ZERO_OK}
  };

  logic clk = 1'b0;
  logic rst;

  mstb_req_if req_ch();
  mstb_rsp_if rsp_ch();

  multi_channel_soft_timer_bank_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // local copy of the timer bank
  logic          bank_registered [NTIM];
  logic          bank_periodic   [NTIM];
  status_t       bank_status     [NTIM];
  logic [31:0]   bank_reload     [NTIM];
  logic [31:0]   bank_count      [NTIM];

  timer_result_t expected_results [$];
  int            mismatch_count = 0;
  bit            send_burst = 1'b0;
  bit            take_burst = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic bank_apply(input cmd_t c, input logic [2:0] i, input logic m,
                            input logic [31:0] t);
    timer_result_t r;
    timer_result_t held;
    bit            have_held;
    logic          ok;
    have_held = 1'b0;
    ok = 1'b1;
    if (c == CMD_TICK) begin
      for (int k = 0; k < NTIM; k++) begin
        if (!bank_registered[k] || bank_status[k] != ST_RUNNING) continue;
        bank_count[k] = bank_count[k] - 32'd1;
        if (bank_count[k] != 32'd0) continue;
        if (bank_periodic[k]) bank_count[k] = bank_reload[k];
        else bank_status[k] = ST_COMPLETED;
        if (have_held) expected_results.push_back(held);
        held = '{1'b1, bank_status[k], 1'b1, 3'(k), 1'b0};
        have_held = 1'b1;
      end
      if (have_held) begin
        held.last = 1'b1;
        expected_results.push_back(held);
      end else begin
        expected_results.push_back(R_ZERO_OK);
      end
    end else begin
      case (c)
        CMD_REGISTER: begin
          bank_periodic[i] = m;
          bank_status[i] = ST_UNUSED;
          bank_registered[i] = 1'b1;
        end
        CMD_UNREGISTER: begin
          if (bank_registered[i]) bank_registered[i] = 1'b0;
          else ok = 1'b0;
        end
        CMD_START: begin
          if (t == 32'd0) begin
            ok = 1'b0;
          end else begin
            bank_reload[i] = t;
            bank_count[i] = t;
            bank_status[i] = ST_RUNNING;
          end
        end
        CMD_STOP: bank_status[i] = ST_STOPPED;
        CMD_RELOAD: begin
          if (bank_reload[i] != 32'd0) begin
            bank_count[i] = bank_reload[i];
            bank_status[i] = ST_RUNNING;
          end
        end
        CMD_STATUS: ;
        default: ok = 1'b0;
      endcase
      r = '{ok, bank_status[i], 1'b0, 3'd0, 1'b1};
      expected_results.push_back(r);
    end
  endtask

  task automatic send_command(input cmd_t c, input logic [2:0] i, input logic m,
                              input logic [31:0] t);
    int gap;
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.command     <= c;
    req_ch.timer_index <= i;
    req_ch.timer_mode  <= m;
    req_ch.ticks       <= t;
    do @(posedge clk); while (!req_ch.ready);
    bank_apply(c, i, m, t);
  endtask

  function automatic logic [31:0] draw_period();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'd0;
    if (sel <= 2) return $urandom;
    return $urandom_range(1, 6);
  endfunction

  function automatic cmd_t draw_command();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return CMD_TICK;
    if (sel < 55) return CMD_START;
    if (sel < 65) return CMD_REGISTER;
    if (sel < 73) return CMD_UNREGISTER;
    if (sel < 80) return CMD_STOP;
    if (sel < 90) return CMD_RELOAD;
    return CMD_STATUS;
  endfunction

  // result side: random back-pressure and checking
  initial begin
    timer_result_t got;
    timer_result_t want;
    int            stall;
    rsp_ch.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      got = '{rsp_ch.ok, status_t'(rsp_ch.timer_status), rsp_ch.expired,
              rsp_ch.expired_index, rsp_ch.last};
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction %p", got));
      end else begin
        want = expected_results.pop_front();
        if (got.ok !== want.ok || got.st !== want.st || got.expired !== want.expired
            || got.index !== want.index || got.last !== want.last)
          report_mismatch($sformatf("got %p, want %p", got, want));
      end
    end
  end

  initial begin
    cmd_t        c;
    logic [2:0]  i;
    logic        m;
    logic [31:0] t;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_STATUS;
    req_ch.timer_index = '0;
    req_ch.timer_mode = 1'b0;
    req_ch.ticks = '0;
    for (int k = 0; k < NTIM; k++) begin
      bank_registered[k] = 1'b0;
      bank_periodic[k] = 1'b0;
      bank_status[k] = ST_UNUSED;
      bank_reload[k] = '0;
      bank_count[k] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < DIR_ROWS; n++) begin
      send_command(dir_rows[n].cmd, dir_rows[n].index, dir_rows[n].mode,
                   dir_rows[n].ticks);
      if (dir_rows[n].typed) begin
        void'(expected_results.pop_back());
        expected_results.push_back(dir_rows[n].want);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      c = draw_command();
      i = 3'($urandom_range(0, NTIM - 1));
      m = 1'($urandom_range(0, 1));
      t = (c == CMD_START) ? draw_period() : $urandom;
      send_command(c, i, m, t);
    end
    req_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
rtl/core/mstb_pkg.sv
rtl/core/mstb_req_if.sv
rtl/core/mstb_rsp_if.sv
rtl/core/mstb_store.sv
rtl/core/mstb_ctrl.sv
rtl/core/multi_channel_soft_timer_bank_top.sv
tb/multi_channel_soft_timer_bank_top_tb.sv
